[hw/rtl/firmware_chunk_receiver_macros.svh]
// assertion macros for the firmware chunk receiver
// used by the top level only; expects clk and rst_n in scope
`ifndef FIRMWARE_CHUNK_RECEIVER_MACROS_SVH
`define FIRMWARE_CHUNK_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define FCR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcr assertion failed");

// next-cycle implication, disabled during reset
`define FCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcr assertion failed");

`endif

[hw/rtl/fcr_pkg.sv]
// shared types and constants for the firmware chunk receiver
// no dependencies
package fcr_pkg;

  localparam int unsigned HDR_BYTES   = 10;
  localparam logic [15:0] MAGIC_RESET = 16'hF17E;
  localparam logic [8:0]  POS_MAX     = 9'd511;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [CFG_ADDR_W-1:0] ADDR_MAGIC_WORD = 3'd0;

  localparam logic [2:0] V_ACCEPTED     = 3'd0;
  localparam logic [2:0] V_DUPLICATE    = 3'd1;
  localparam logic [2:0] V_SHORT        = 3'd2;
  localparam logic [2:0] V_BAD_MAGIC    = 3'd3;
  localparam logic [2:0] V_LEN_MISMATCH = 3'd4;
  localparam logic [2:0] V_CHECKSUM_BAD = 3'd5;
  localparam logic [2:0] V_OUT_OF_ORDER = 3'd6;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        verdict_valid;
    logic [2:0]  verdict;
    logic [15:0] chunk_number;
    logic        send_ack;
    logic        firmware_complete;
    logic [15:0] bytes_received;
    logic [7:0]  chunks_received;
  } fcr_result_t;

endpackage

[hw/rtl/firmware_chunk_receiver.sv]
// firmware chunk receiver: parses datagrams byte by byte and gives verdicts
// depends on fcr_pkg, fcr_core, fcr_out_buf and firmware_chunk_receiver_macros.svh
//
// input channel: one datagram byte per transaction (in_rx_byte), with
//   in_end_of_datagram high on the final byte
// result channel: one transaction for each payload byte (byte ten onward)
//   and for each final byte; header bytes that are not final give nothing
// config: apb-style, magic_word at byte address 0, written while idle
// output: each result is registered in the output register or the skid entry
// throughput: one byte per cycle while in_stall is low; header capture, the
//   16-bit sum add and the verdict compares all sit between the state
//   registers and the output register
// stall: the output register plus one skid entry absorb one result while
//   out_stall is high; in_stall rises once the skid entry is used and
//   drops the cycle after the result channel moves again
// reset: counters, expected chunk and parse state clear to zero, the
//   magic word returns to 0xF17E and no result is pending
`include "firmware_chunk_receiver_macros.svh"

module firmware_chunk_receiver
  import fcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  input  logic                  in_end_of_datagram,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_payload_valid,
  output logic [7:0]            out_payload_byte,
  output logic                  out_verdict_valid,
  output logic [2:0]            out_verdict,
  output logic [15:0]           out_chunk_number,
  output logic                  out_send_ack,
  output logic                  out_firmware_complete,
  output logic [15:0]           out_bytes_received,
  output logic [7:0]            out_chunks_received,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] magic_r;
  logic        accept;
  logic        push;
  logic        full;
  fcr_result_t core_res;
  fcr_result_t out_res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_MAGIC_WORD)) begin
      magic_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr == ADDR_MAGIC_WORD) ? {16'd0, magic_r} : 32'd0;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  fcr_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .rx_byte         (in_rx_byte),
    .end_of_datagram (in_end_of_datagram),
    .magic_word      (magic_r),
    .push            (push),
    .result          (core_res)
  );

  fcr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_res),
    .full      (full)
  );

  assign out_payload_valid     = out_res.payload_valid;
  assign out_payload_byte      = out_res.payload_byte;
  assign out_verdict_valid     = out_res.verdict_valid;
  assign out_verdict           = out_res.verdict;
  assign out_chunk_number      = out_res.chunk_number;
  assign out_send_ack          = out_res.send_ack;
  assign out_firmware_complete = out_res.firmware_complete;
  assign out_bytes_received    = out_res.bytes_received;
  assign out_chunks_received   = out_res.chunks_received;

  // skid entry in use means the output register holds a result too
  `FCR_ASSERT_IMPL(a_skid_implies_out, in_stall, out_valid)
  // every result carries a payload byte or a verdict
  `FCR_ASSERT_IMPL(a_result_nonempty, out_valid, out_payload_valid || out_verdict_valid)
  // completion is only flagged on an acknowledged chunk
  `FCR_ASSERT_IMPL(a_complete_acked, out_valid && out_firmware_complete, out_send_ack)
  // acks only go with accepted or duplicate verdicts
  `FCR_ASSERT_IMPL(a_ack_verdict, out_valid && out_send_ack,
                   out_verdict_valid && (out_verdict == V_ACCEPTED || out_verdict == V_DUPLICATE))

endmodule

[hw/rtl/fcr_core.sv]
// header parse, payload sum and verdict for one byte per cycle while accept is high
// depends on fcr_pkg
module fcr_core
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_datagram,
  input  logic [15:0] magic_word,
  output logic        push,
  output fcr_result_t result
);

  logic [8:0]  pos_r, pos_nxt;
  logic [15:0] magic_r, magic_nxt;
  logic [15:0] chunk_r, chunk_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [15:0] chk_r, chk_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [7:0]  acc_chunks_r, acc_chunks_nxt;
  logic [15:0] acc_bytes_r, acc_bytes_nxt;

  logic        is_pay;
  logic [15:0] sum_cur;
  logic [15:0] chk_cur;
  logic [9:0]  len;
  logic [9:0]  len_expect;
  logic [2:0]  vd;
  logic        ack;
  logic        take;
  logic        done;

  assign is_pay     = (pos_r >= 9'(HDR_BYTES));
  assign sum_cur    = sum_r + (is_pay ? {8'd0, rx_byte} : 16'd0);
  // the last checksum byte may be the final byte itself
  assign chk_cur    = (pos_r == 9'd9) ? {chk_r[15:8], rx_byte} : chk_r;
  assign len        = {1'b0, pos_r} + 10'd1;
  assign len_expect = 10'(HDR_BYTES) + {2'd0, plen_r};

  always_comb begin
    vd   = V_ACCEPTED;
    ack  = 1'b0;
    take = 1'b0;
    priority if (len < 10'(HDR_BYTES)) begin
      vd = V_SHORT;
    end else if (magic_r != magic_word) begin
      vd = V_BAD_MAGIC;
    end else if (len != len_expect) begin
      vd = V_LEN_MISMATCH;
    end else if (sum_cur != chk_cur) begin
      vd = V_CHECKSUM_BAD;
    end else if (chunk_r == exp_r) begin
      vd   = V_ACCEPTED;
      ack  = 1'b1;
      take = 1'b1;
    end else if (chunk_r < exp_r) begin
      vd  = V_DUPLICATE;
      ack = 1'b1;
    end else begin
      vd = V_OUT_OF_ORDER;
    end
  end

  always_comb begin
    acc_chunks_nxt = acc_chunks_r;
    acc_bytes_nxt  = acc_bytes_r;
    exp_nxt        = exp_r;
    if (accept && end_of_datagram && take) begin
      acc_chunks_nxt = acc_chunks_r + 8'd1;
      acc_bytes_nxt  = acc_bytes_r + {8'd0, plen_r};
      exp_nxt        = exp_r + 16'd1;
    end
  end

  assign done = ack && (total_r != 8'd0) && (acc_chunks_nxt == total_r)
             && (chunk_r == {8'd0, total_r - 8'd1});

  always_comb begin
    pos_nxt   = pos_r;
    magic_nxt = magic_r;
    chunk_nxt = chunk_r;
    plen_nxt  = plen_r;
    total_nxt = total_r;
    chk_nxt   = chk_r;
    sum_nxt   = sum_r;
    if (accept) begin
      unique case (pos_r)
        9'd0:    magic_nxt = {rx_byte, magic_r[7:0]};
        9'd1:    magic_nxt = {magic_r[15:8], rx_byte};
        9'd2:    chunk_nxt = {rx_byte, chunk_r[7:0]};
        9'd3:    chunk_nxt = {chunk_r[15:8], rx_byte};
        9'd4, 9'd5: ;
        9'd6:    plen_nxt  = rx_byte;
        9'd7:    total_nxt = rx_byte;
        9'd8:    chk_nxt   = {rx_byte, chk_r[7:0]};
        9'd9:    chk_nxt   = {chk_r[15:8], rx_byte};
        default: sum_nxt   = sum_cur;
      endcase
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + 9'd1;
      end
      // per-datagram state starts over after the final byte
      if (end_of_datagram) begin
        pos_nxt   = '0;
        magic_nxt = '0;
        chunk_nxt = '0;
        plen_nxt  = '0;
        total_nxt = '0;
        chk_nxt   = '0;
        sum_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      magic_r      <= '0;
      chunk_r      <= '0;
      plen_r       <= '0;
      total_r      <= '0;
      chk_r        <= '0;
      sum_r        <= '0;
      exp_r        <= '0;
      acc_chunks_r <= '0;
      acc_bytes_r  <= '0;
    end else begin
      pos_r        <= pos_nxt;
      magic_r      <= magic_nxt;
      chunk_r      <= chunk_nxt;
      plen_r       <= plen_nxt;
      total_r      <= total_nxt;
      chk_r        <= chk_nxt;
      sum_r        <= sum_nxt;
      exp_r        <= exp_nxt;
      acc_chunks_r <= acc_chunks_nxt;
      acc_bytes_r  <= acc_bytes_nxt;
    end
  end

  assign push = accept && (end_of_datagram || is_pay);

  always_comb begin
    result.payload_valid     = is_pay;
    result.payload_byte      = is_pay ? rx_byte : 8'd0;
    result.verdict_valid     = end_of_datagram;
    result.verdict           = end_of_datagram ? vd : V_ACCEPTED;
    result.chunk_number      = (end_of_datagram && (vd != V_SHORT)) ? chunk_r : 16'd0;
    result.send_ack          = end_of_datagram && ack;
    result.firmware_complete = end_of_datagram && done;
    result.bytes_received    = acc_bytes_nxt;
    result.chunks_received   = acc_chunks_nxt;
  end

endmodule

[hw/rtl/fcr_out_buf.sv]
// output register plus one skid entry for the result channel
// depends on fcr_pkg
module fcr_out_buf
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  fcr_result_t push_data,
  input  logic        out_stall,
  output logic        out_valid,
  output fcr_result_t out_data,
  output logic        full
);

  logic        main_v_r, main_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  fcr_result_t main_r, main_nxt;
  fcr_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop = main_v_r && !out_stall;

  // push only arrives while the skid entry is empty
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign full      = skid_v_r;

endmodule
